>>> src/linear_threshold_classifier_tally_assert.svh
// Assertion macros shared by the classifier tally RTL.
`ifndef LINEAR_THRESHOLD_CLASSIFIER_TALLY_ASSERT_SVH
`define LINEAR_THRESHOLD_CLASSIFIER_TALLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTCT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ltct: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ltct: assertion failed");

`endif

>>> src/ltct_pkg.sv
// Shared constants, codes and types of the classifier tally.
package ltct_pkg;

  localparam int unsigned RULE_COUNT  = 1024;
  localparam int unsigned RULE_ADDR_W = $clog2(RULE_COUNT);
  localparam int unsigned RIDX_W      = 10;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned CNT_W       = 32;

  // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT, exact for any 32-bit x
  localparam logic [31:0] DIV100_MUL   = 32'h51EB_851F;
  localparam int unsigned DIV100_SHIFT = 37;
  localparam int unsigned QUOT_W       = 64 - DIV100_SHIFT;

  localparam logic [CNT_W-1:0]           MISS_BONUS      = CNT_W'(5);
  localparam logic signed [WEIGHT_W-1:0] ZERO_WEIGHT_FIX = WEIGHT_W'(1);
  localparam logic signed [WEIGHT_W-1:0] THRESH_RESET    = WEIGHT_W'(500);

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_HIT   = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_e;

  // Close or clear transaction handed to the tally pipe
  typedef struct packed {
    logic                      clear;
    logic                      is_spam;
    logic                      over;
    logic signed [SCORE_W-1:0] score;
    logic [SCORE_W-1:0]        distance;
  } ltct_close_t;

endpackage

>>> src/ltct_if.sv
// Valid/ready channel interfaces: request, result and threshold write.
interface ltct_req_if import ltct_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [RIDX_W-1:0]          rule_index;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [WEIGHT_W-1:0] bound_low;
  logic signed [WEIGHT_W-1:0] bound_high;
  logic                       fixed_rule;
  logic                       message_is_spam;

  modport source (
    output valid, req_type, rule_index, weight, bound_low, bound_high, fixed_rule,
           message_is_spam,
    input  ready
  );
  modport sink (
    input  valid, req_type, rule_index, weight, bound_low, bound_high, fixed_rule,
           message_is_spam,
    output ready
  );
endinterface

interface ltct_res_if import ltct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] message_score;
  logic                      judged_spam;
  logic [CNT_W-1:0]          correct_ham_count;
  logic [CNT_W-1:0]          correct_spam_count;
  logic [CNT_W-1:0]          false_positive_count;
  logic [CNT_W-1:0]          false_negative_count;
  logic [CNT_W-1:0]          false_positive_penalty;
  logic [CNT_W-1:0]          false_negative_penalty;

  modport source (
    output valid, message_score, judged_spam, correct_ham_count, correct_spam_count,
           false_positive_count, false_negative_count, false_positive_penalty,
           false_negative_penalty,
    input  ready
  );
  modport sink (
    input  valid, message_score, judged_spam, correct_ham_count, correct_spam_count,
           false_positive_count, false_negative_count, false_positive_penalty,
           false_negative_penalty,
    output ready
  );
endinterface

interface ltct_cfg_if import ltct_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] spam_threshold;

  modport source (output valid, spam_threshold, input ready);
  modport sink (input valid, spam_threshold, output ready);
endinterface

>>> src/ltct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ltct_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ltct_tally.sv
// Tally pipe: penalty divide by 100, saturating counters, result register.
`include "linear_threshold_classifier_tally_assert.svh"

module ltct_tally import ltct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ltct_close_t       in_item_i,
  ltct_res_if.source        res_o
);

  // stage 2: distance registered, multiply by reciprocal
  logic        s2_valid_q;
  ltct_close_t s2_q;
  // stage 3: quotient registered, counter update
  logic                      s3_valid_q;
  logic                      s3_clear_q;
  logic                      s3_spam_q;
  logic                      s3_over_q;
  logic signed [SCORE_W-1:0] s3_score_q;
  logic [QUOT_W-1:0]         s3_quot_q;

  logic [CNT_W-1:0] hr_cnt_q, hr_cnt_d;
  logic [CNT_W-1:0] sr_cnt_q, sr_cnt_d;
  logic [CNT_W-1:0] fp_cnt_q, fp_cnt_d;
  logic [CNT_W-1:0] fn_cnt_q, fn_cnt_d;
  logic [CNT_W-1:0] fp_pen_q, fp_pen_d;
  logic [CNT_W-1:0] fn_pen_q, fn_pen_d;

  logic                      out_valid_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic                      out_spam_q;
  logic [CNT_W-1:0]          out_hr_q, out_sr_q, out_fp_q, out_fn_q, out_fpp_q, out_fnp_q;

  logic        out_free;
  logic        s3_adv;
  logic        s3_free;
  logic        s2_free;
  logic [63:0] prod;
  logic [CNT_W:0] fp_pen_sum, fn_pen_sum;

  assign out_free   = !out_valid_q || res_o.ready;
  assign s3_adv     = s3_valid_q && (s3_clear_q || out_free);
  assign s3_free    = !s3_valid_q || s3_adv;
  assign s2_free    = !s2_valid_q || s3_free;
  assign in_ready_o = s2_free;

  assign prod = 64'(s2_q.distance) * 64'(DIV100_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= in_valid_i;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && in_valid_i) begin
      s2_q <= in_item_i;
    end
    if (s3_free && s2_valid_q) begin
      s3_clear_q <= s2_q.clear;
      s3_spam_q  <= s2_q.is_spam;
      s3_over_q  <= s2_q.over;
      s3_score_q <= s2_q.score;
      s3_quot_q  <= prod[63:DIV100_SHIFT];
    end
  end

  assign fp_pen_sum = {1'b0, fp_pen_q} + (CNT_W+1)'(s3_quot_q) + {1'b0, MISS_BONUS};
  assign fn_pen_sum = {1'b0, fn_pen_q} + (CNT_W+1)'(s3_quot_q) + {1'b0, MISS_BONUS};

  always_comb begin
    hr_cnt_d = hr_cnt_q;
    sr_cnt_d = sr_cnt_q;
    fp_cnt_d = fp_cnt_q;
    fn_cnt_d = fn_cnt_q;
    fp_pen_d = fp_pen_q;
    fn_pen_d = fn_pen_q;
    if (s3_clear_q) begin
      hr_cnt_d = '0;
      sr_cnt_d = '0;
      fp_cnt_d = '0;
      fn_cnt_d = '0;
      fp_pen_d = '0;
      fn_pen_d = '0;
    end else begin
      unique case ({s3_spam_q, s3_over_q})
        2'b11: sr_cnt_d = (sr_cnt_q == '1) ? sr_cnt_q : sr_cnt_q + 1'b1;
        2'b10: begin
          fn_cnt_d = (fn_cnt_q == '1) ? fn_cnt_q : fn_cnt_q + 1'b1;
          fn_pen_d = fn_pen_sum[CNT_W] ? '1 : fn_pen_sum[CNT_W-1:0];
        end
        2'b01: begin
          fp_cnt_d = (fp_cnt_q == '1) ? fp_cnt_q : fp_cnt_q + 1'b1;
          fp_pen_d = fp_pen_sum[CNT_W] ? '1 : fp_pen_sum[CNT_W-1:0];
        end
        default: hr_cnt_d = (hr_cnt_q == '1) ? hr_cnt_q : hr_cnt_q + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_cnt_q    <= '0;
      sr_cnt_q    <= '0;
      fp_cnt_q    <= '0;
      fn_cnt_q    <= '0;
      fp_pen_q    <= '0;
      fn_pen_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_adv) begin
        hr_cnt_q <= hr_cnt_d;
        sr_cnt_q <= sr_cnt_d;
        fp_cnt_q <= fp_cnt_d;
        fn_cnt_q <= fn_cnt_d;
        fp_pen_q <= fp_pen_d;
        fn_pen_q <= fn_pen_d;
      end
      if (out_free) begin
        out_valid_q <= s3_adv && !s3_clear_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv && !s3_clear_q) begin
      out_score_q <= s3_score_q;
      out_spam_q  <= s3_over_q;
      out_hr_q    <= hr_cnt_d;
      out_sr_q    <= sr_cnt_d;
      out_fp_q    <= fp_cnt_d;
      out_fn_q    <= fn_cnt_d;
      out_fpp_q   <= fp_pen_d;
      out_fnp_q   <= fn_pen_d;
    end
  end

  assign res_o.valid                  = out_valid_q;
  assign res_o.message_score          = out_score_q;
  assign res_o.judged_spam            = out_spam_q;
  assign res_o.correct_ham_count      = out_hr_q;
  assign res_o.correct_spam_count     = out_sr_q;
  assign res_o.false_positive_count   = out_fp_q;
  assign res_o.false_negative_count   = out_fn_q;
  assign res_o.false_positive_penalty = out_fpp_q;
  assign res_o.false_negative_penalty = out_fnp_q;

  // a clear leaves the tallies at zero; checked on both penalties, the ham count and the fp count
  `LTCT_ASSERT_NEXT(a_clear_zeroes, clk_i, rst_ni, s3_adv && s3_clear_q,
    fp_pen_q == '0 && fn_pen_q == '0 && hr_cnt_q == '0 && fp_cnt_q == '0)
  // a saturated false positive count stays saturated until cleared
  `LTCT_ASSERT_NEXT(a_fp_sat_holds, clk_i, rst_ni,
    s3_adv && !s3_clear_q && fp_cnt_q == '1, fp_cnt_q == '1)

endmodule

>>> src/linear_threshold_classifier_tally.sv
// Top level of the linear threshold classifier tally.
// Linear threshold classifier tally. Takes one request transaction per clock on
// req_i unless stalled: weight writes, rule hits, message closes and tally
// clears. A weight write is clamped and stored in the rule weight RAM in the
// accept cycle; a hit reads the RAM in its accept cycle and the weight is summed
// into the running score register in the next cycle, so hits stream at one per
// clock while req_i is not stalled. A close enters a three-stage tally pipe
// (threshold compare, multiply-by-reciprocal divide by 100, saturating counter
// update) whose result is registered onto res_o; the request side keeps
// accepting while results wait, until the tally pipe fills. The user must write
// the threshold over cfg_i, always ready, only while the block is idle; not enforced.
`include "linear_threshold_classifier_tally_assert.svh"

module linear_threshold_classifier_tally import ltct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltct_cfg_if.sink   cfg_i,
  ltct_req_if.sink   req_i,
  ltct_res_if.source res_o
);

  localparam int unsigned EXT_W = SCORE_W - WEIGHT_W + 1;

  logic signed [WEIGHT_W-1:0] thresh_q;
  logic signed [SCORE_W-1:0]  score_q, score_d;

  logic       s1_valid_q;
  req_type_e  s1_op_q;
  logic       s1_in_range_q;
  logic       s1_spam_q;

  req_type_e                  in_op;
  logic                       in_accept;
  logic                       in_range;
  logic                       ram_we;
  logic                       ram_re;
  logic [RULE_ADDR_W-1:0]     ram_addr;
  logic signed [WEIGHT_W-1:0] wr_weight;
  logic [WEIGHT_W-1:0]        rd_weight;

  logic                  s1_adv;
  logic                  tally_ready;
  ltct_close_t           tally_item;
  logic signed [SCORE_W:0] hit_sum;
  logic signed [SCORE_W:0] thr_ext;
  logic signed [SCORE_W:0] d_fp;
  logic signed [SCORE_W:0] d_fn;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_i.valid) begin
      thresh_q <= cfg_i.spam_threshold;
    end
  end

  // stage 0: accept, clamp and write, or issue a weight read
  assign in_op     = req_type_e'(req_i.req_type);
  assign in_accept = req_i.valid && req_i.ready;
  assign in_range  = {{(32-RIDX_W){1'b0}}, req_i.rule_index} < 32'(RULE_COUNT);
  assign ram_addr  = RULE_ADDR_W'(req_i.rule_index);
  assign ram_we    = in_accept && (in_op == REQ_WRITE) && in_range;
  assign ram_re    = in_accept && (in_op == REQ_HIT);

  always_comb begin
    wr_weight = req_i.weight;
    if (!req_i.fixed_rule) begin
      priority if (req_i.weight == '0) begin
        wr_weight = ZERO_WEIGHT_FIX;
      end else if (req_i.weight < req_i.bound_low) begin
        wr_weight = req_i.bound_low;
      end else if (req_i.weight > req_i.bound_high) begin
        wr_weight = req_i.bound_high;
      end else begin
        wr_weight = req_i.weight;
      end
    end
  end

  ltct_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (RULE_COUNT)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (wr_weight),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (rd_weight)
  );

  // stage 1: hits finish here; closes and clears wait for the tally pipe
  always_comb begin
    unique case (s1_op_q)
      REQ_HIT:   s1_adv = s1_valid_q;
      REQ_CLOSE: s1_adv = s1_valid_q && tally_ready;
      REQ_CLEAR: s1_adv = s1_valid_q && tally_ready;
      REQ_WRITE: s1_adv = s1_valid_q;
      default:   s1_adv = s1_valid_q;
    endcase
  end

  assign req_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid && (in_op != REQ_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q       <= in_op;
      s1_in_range_q <= in_range;
      s1_spam_q     <= req_i.message_is_spam;
    end
  end

  assign hit_sum = {score_q[SCORE_W-1], score_q}
                 + (s1_in_range_q ? {{EXT_W{rd_weight[WEIGHT_W-1]}}, rd_weight} : '0);

  always_comb begin
    score_d = score_q;
    if (s1_adv) begin
      if (s1_op_q == REQ_HIT) begin
        unique case (hit_sum[SCORE_W:SCORE_W-1])
          2'b01:   score_d = {1'b0, {(SCORE_W-1){1'b1}}};
          2'b10:   score_d = {1'b1, {(SCORE_W-1){1'b0}}};
          default: score_d = hit_sum[SCORE_W-1:0];
        endcase
      end else if (s1_op_q == REQ_CLOSE) begin
        score_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
    end else begin
      score_q <= score_d;
    end
  end

  // both distances side by side; the sign of score - threshold picks one
  assign thr_ext = {{EXT_W{thresh_q[WEIGHT_W-1]}}, thresh_q};
  assign d_fp    = {score_q[SCORE_W-1], score_q} - thr_ext;
  assign d_fn    = thr_ext - {score_q[SCORE_W-1], score_q};

  always_comb begin
    tally_item.clear    = (s1_op_q == REQ_CLEAR);
    tally_item.is_spam  = s1_spam_q;
    tally_item.over     = !d_fp[SCORE_W];
    tally_item.score    = score_q;
    tally_item.distance = d_fp[SCORE_W] ? d_fn[SCORE_W-1:0] : d_fp[SCORE_W-1:0];
  end

  ltct_tally u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid_q && (s1_op_q == REQ_CLOSE || s1_op_q == REQ_CLEAR)),
    .in_ready_o (tally_ready),
    .in_item_i  (tally_item),
    .res_o      (res_o)
  );

  // a closed message leaves the running score at zero
  `LTCT_ASSERT_NEXT(a_close_resets_score, clk_i, rst_ni,
    s1_adv && s1_op_q == REQ_CLOSE, score_q == '0)
  // the request side stalls only behind a held close or clear
  `LTCT_ASSERT_NOW(a_stall_has_cause, clk_i, rst_ni, !req_i.ready,
    s1_valid_q && !tally_ready && (s1_op_q == REQ_CLOSE || s1_op_q == REQ_CLEAR))

endmodule

>>> tb/ltct_tally_check.sv
// Tally checker: predicts classifier results from observed transactions and compares them.
`timescale 1ns / 1ps

module ltct_tally_check import ltct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltct_cfg_if         cfg_i,
  ltct_req_if         req_i,
  ltct_res_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      judged;
    logic [CNT_W-1:0]          ham_ok;
    logic [CNT_W-1:0]          spam_ok;
    logic [CNT_W-1:0]          fp_cnt;
    logic [CNT_W-1:0]          fn_cnt;
    logic [CNT_W-1:0]          fp_pen;
    logic [CNT_W-1:0]          fn_pen;
  } tally_t;

  logic signed [WEIGHT_W-1:0] rule_weight [RULE_COUNT];
  logic signed [WEIGHT_W-1:0] threshold;
  logic signed [SCORE_W-1:0]  msg_score;
  logic [CNT_W-1:0]           ham_ok, spam_ok, fp_cnt, fn_cnt, fp_pen, fn_pen;
  tally_t                     expected_tallies [$];
  tally_t                     want;
  int unsigned                mismatches;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, longint b);
    longint t;
    t = longint'(a) + b;
    return (t > longint'(32'hFFFF_FFFF)) ? '1 : t[CNT_W-1:0];
  endfunction

  function automatic void store_weight(logic [RIDX_W-1:0] idx, logic signed [WEIGHT_W-1:0] w,
                                       logic signed [WEIGHT_W-1:0] lo,
                                       logic signed [WEIGHT_W-1:0] hi, logic fixed);
    logic signed [WEIGHT_W-1:0] v;
    v = w;
    if (!fixed) begin
      // zero fix wins over the bounds; low bound is tested first
      if (v == 0) v = ZERO_WEIGHT_FIX;
      else if (v < lo) v = lo;
      else if (v > hi) v = hi;
    end
    if (idx < RULE_COUNT) rule_weight[idx] = v;
  endfunction

  function automatic void add_hit(logic [RIDX_W-1:0] idx);
    longint s;
    s = longint'(msg_score);
    if (idx < RULE_COUNT) s = s + longint'(rule_weight[idx]);
    if (s > longint'(32'sh7FFF_FFFF)) s = longint'(32'sh7FFF_FFFF);
    if (s < longint'(32'sh8000_0000)) s = longint'(32'sh8000_0000);
    msg_score = s[SCORE_W-1:0];
  endfunction

  function automatic tally_t close_message(logic is_spam);
    tally_t t;
    logic   over;
    longint miss_dist;
    over = msg_score >= threshold;
    miss_dist = over ? longint'(msg_score) - longint'(threshold)
                     : longint'(threshold) - longint'(msg_score);
    if (is_spam) begin
      if (over) begin
        spam_ok = sat_inc(spam_ok);
      end else begin
        fn_cnt = sat_inc(fn_cnt);
        fn_pen = sat_add(fn_pen, miss_dist / 100 + 5);
      end
    end else begin
      if (over) begin
        fp_cnt = sat_inc(fp_cnt);
        fp_pen = sat_add(fp_pen, miss_dist / 100 + 5);
      end else begin
        ham_ok = sat_inc(ham_ok);
      end
    end
    t = '{score: msg_score, judged: over, ham_ok: ham_ok, spam_ok: spam_ok,
          fp_cnt: fp_cnt, fn_cnt: fn_cnt, fp_pen: fp_pen, fn_pen: fn_pen};
    msg_score = '0;
    return t;
  endfunction

  task automatic compare_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected 0x%h, got 0x%h", fname, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold = THRESH_RESET;
      msg_score = '0;
      ham_ok = '0;
      spam_ok = '0;
      fp_cnt = '0;
      fn_cnt = '0;
      fp_pen = '0;
      fn_pen = '0;
      expected_tallies.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) threshold = cfg_i.spam_threshold;

      // results are checked before this edge's request is predicted
      if (res_i.valid && res_i.ready) begin
        if (expected_tallies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction, score 0x%h", res_i.message_score);
        end else begin
          want = expected_tallies.pop_front();
          compare_field("message_score", want.score, res_i.message_score);
          compare_field("judged_spam", 32'(want.judged), 32'(res_i.judged_spam));
          compare_field("correct_ham_count", want.ham_ok, res_i.correct_ham_count);
          compare_field("correct_spam_count", want.spam_ok, res_i.correct_spam_count);
          compare_field("false_positive_count", want.fp_cnt, res_i.false_positive_count);
          compare_field("false_negative_count", want.fn_cnt, res_i.false_negative_count);
          compare_field("false_positive_penalty", want.fp_pen, res_i.false_positive_penalty);
          compare_field("false_negative_penalty", want.fn_pen, res_i.false_negative_penalty);
        end
      end

      if (req_i.valid && req_i.ready) begin
        case (req_type_e'(req_i.req_type))
          REQ_WRITE: begin
            store_weight(req_i.rule_index, req_i.weight, req_i.bound_low, req_i.bound_high,
                         req_i.fixed_rule);
          end
          REQ_HIT: begin
            add_hit(req_i.rule_index);
          end
          REQ_CLOSE: begin
            expected_tallies.push_back(close_message(req_i.message_is_spam));
          end
          REQ_CLEAR: begin
            ham_ok = '0;
            spam_ok = '0;
            fp_cnt = '0;
            fn_cnt = '0;
            fp_pen = '0;
            fn_pen = '0;
          end
          default: ;
        endcase
      end
    end
    pending_o <= expected_tallies.size();
    fail_count_o <= mismatches;
  end

endmodule

>>> tb/testbench.sv
// Testbench top: drives requests, threshold writes and result backpressure, gives the verdict.
`timescale 1ns / 1ps

module testbench import ltct_pkg::*;;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  bit          no_idle;
  bit          rule_set [RULE_COUNT];
  int          written_list [$];
  int          phase_items;
  int          wait_cycles;
  logic signed [WEIGHT_W-1:0] thresh_plan [6];

  ltct_cfg_if cfg_ch ();
  ltct_req_if req_ch ();
  ltct_res_if res_ch ();

  linear_threshold_classifier_tally dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  ltct_tally_check tally_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_ch),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // one request transaction; valid stays high into the next call unless it idles
  task automatic send_req(req_type_e kind, logic [RIDX_W-1:0] idx,
                          logic signed [WEIGHT_W-1:0] w, logic signed [WEIGHT_W-1:0] lo,
                          logic signed [WEIGHT_W-1:0] hi, logic fixed, logic spam);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= kind;
    req_ch.rule_index      <= idx;
    req_ch.weight          <= w;
    req_ch.bound_low       <= lo;
    req_ch.bound_high      <= hi;
    req_ch.fixed_rule      <= fixed;
    req_ch.message_is_spam <= spam;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    phase_items++;
    if (kind == REQ_WRITE && !rule_set[idx]) begin
      rule_set[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  // unused fields get random noise
  task automatic send_noisy(req_type_e kind, logic [RIDX_W-1:0] idx);
    send_req(kind, idx, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
             1'($urandom));
  endtask

  task automatic send_write(logic [RIDX_W-1:0] idx, logic signed [WEIGHT_W-1:0] w,
                            logic signed [WEIGHT_W-1:0] lo, logic signed [WEIGHT_W-1:0] hi,
                            logic fixed);
    send_req(REQ_WRITE, idx, w, lo, hi, fixed, 1'($urandom));
  endtask

  task automatic send_close(logic spam);
    send_req(REQ_CLOSE, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom), spam);
  endtask

  function automatic logic [RIDX_W-1:0] pick_rule();
    return RIDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // clears and hits produce nothing; let the tally pipe empty
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(logic signed [WEIGHT_W-1:0] v);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.spam_threshold <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int budget);
    int    pick;
    int    n_hits;
    logic signed [WEIGHT_W-1:0] w;
    logic signed [WEIGHT_W-1:0] lo;
    logic signed [WEIGHT_W-1:0] hi;
    phase_items = 0;
    no_idle = 1'b0;
    while (phase_items < budget) begin
      if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        w  = ($urandom_range(0, 7) == 0) ? '0 : 16'($urandom);
        lo = 16'($urandom);
        hi = 16'($urandom);
        // mostly ordered bounds, sometimes inverted
        if ($urandom_range(0, 3) != 0 && lo > hi) begin
          lo = hi;
          hi = 16'($urandom);
          if (hi < lo) hi = lo;
        end
        send_write(10'($urandom), w, lo, hi, 1'($urandom));
      end else if (pick < 20) begin
        send_noisy(REQ_CLEAR, 10'($urandom));
      end else if (pick < 24) begin
        send_close(1'($urandom));
      end else begin
        n_hits = $urandom_range(1, 8);
        repeat (n_hits) send_noisy(REQ_HIT, pick_rule());
        send_close(1'($urandom));
      end
    end
  endtask

  // result side backpressure
  initial begin
    int gap;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.spam_threshold  <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= REQ_WRITE;
    req_ch.rule_index      <= '0;
    req_ch.weight          <= '0;
    req_ch.bound_low       <= '0;
    req_ch.bound_high      <= '0;
    req_ch.fixed_rule      <= 1'b0;
    req_ch.message_is_spam <= 1'b0;
    res_ch.ready           <= 1'b0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset threshold of 500
    send_write(10'd0, 16'sd0, 16'sd100, 16'sd200, 1'b0);        // zero fix outside bounds
    send_write(10'd1023, -16'sd32768, 16'sd0, 16'sd0, 1'b1);
    send_write(10'd1, 16'sd32767, -16'sd50, 16'sd300, 1'b0);    // clamp high
    send_write(10'd2, -16'sd32768, -16'sd1000, 16'sd1000, 1'b0); // clamp low
    send_write(10'd3, 16'sd700, 16'sd900, 16'sd100, 1'b0);      // inverted bounds
    send_write(10'd4, 16'sd50, 16'sd10, 16'sd100, 1'b0);
    send_write(10'd5, 16'sd32767, -16'sd1, 16'sd1, 1'b1);
    send_write(10'd6, 16'sd0, 16'sd5, 16'sd9, 1'b1);            // fixed zero kept
    send_close(1'b0);                                           // empty ham
    send_close(1'b1);                                           // empty spam, missed
    send_noisy(REQ_HIT, 10'd5);
    send_noisy(REQ_HIT, 10'd5);
    send_close(1'b0);                                           // false positive
    send_noisy(REQ_HIT, 10'd0);
    send_noisy(REQ_HIT, 10'd3);
    send_close(1'b1);                                           // spam over threshold
    send_noisy(REQ_HIT, 10'd1023);
    send_noisy(REQ_HIT, 10'd2);
    send_close(1'b0);
    send_write(10'd7, 16'sd500, 16'sd0, 16'sd0, 1'b1);
    send_noisy(REQ_HIT, 10'd7);
    send_close(1'b0);                                           // score equals threshold
    send_noisy(REQ_CLEAR, 10'd0);
    send_noisy(REQ_HIT, 10'd7);
    send_close(1'b1);
    drain();

    thresh_plan[0] = 16'sh7FFF;
    thresh_plan[1] = 16'sh8000;
    thresh_plan[2] = '0;
    thresh_plan[3] = 16'($urandom);
    thresh_plan[4] = 16'($urandom_range(0, 2000)) - 16'sd1000;
    thresh_plan[5] = 16'($urandom);
    foreach (thresh_plan[p]) begin
      write_threshold(thresh_plan[p]);
      random_phase(115);
      drain();
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (wait_cycles = 0; pending != 0 && wait_cycles < 2000; wait_cycles++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
